[src/ptt_pkg.sv]
// Package for the pending request timeout table.
// Holds item types, command and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package ptt_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_EXPIRE = 2'd3
  } cmd_e;

  // Status codes of a result item
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  // Fixed field widths
  localparam int unsigned TAG_W  = 64;
  localparam int unsigned NAME_W = 16;
  localparam int unsigned TMO_W  = 31;
  localparam int unsigned TIME_W = 40;

  // Input item
  typedef struct packed {
    cmd_e                command;
    logic [TAG_W-1:0]    corr_tag;
    logic [NAME_W-1:0]   name_code;
    logic [TMO_W-1:0]    timeout;
    logic [TIME_W-1:0]   now_time;
  } ptt_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]          status;
    logic                is_pending;
    logic                expired_found;
    logic [2:0]          expired_slot;
    logic [TAG_W-1:0]    expired_tag;
    logic [NAME_W-1:0]   expired_name;
    logic [3:0]          entry_count;
  } ptt_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture item, restart scan
    logic scan;    // read one table entry
    logic commit;  // update table, register result
  } ptt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // entry being read is the last one
  } ptt_stat_t;

endpackage

[src/ptt_ctrl.sv]
// Controller of the pending request timeout table.
// Sequences load, table scan, drain and commit for each item.
// Depends on ptt_pkg.
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ptt_stat_t stat,
  output ptt_cmd_t  cmd,
  output logic      busy
);

  state_e state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // An accepted item always starts a scan
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_SCAN))
    else $error("accepted item did not start a scan");

  // Commit follows the drain cycle and is never repeated
  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit && $past(state == ST_COMMIT) && $past(state, 2) == ST_DRAIN)
    else $error("commit not preceded by drain or repeated");

  // No new item is taken while one is in progress
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("load while busy");

endmodule

[src/ptt_datapath.sv]
// Datapath of the pending request timeout table.
// Holds the entry memory, valid bits, entry count, scan finders and the
// result register. Depends on ptt_pkg.
module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int unsigned DEPTH   = 8,
  parameter int unsigned TAG_LEN = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  ptt_in_t   request,
  input  ptt_cmd_t  cmd,
  output ptt_stat_t stat,
  output ptt_out_t  response,
  output logic      done
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [TAG_LEN-1:0] tag;
    logic [NAME_W-1:0]  name;
    logic [TIME_W-1:0]  deadline;
  } entry_t;

  // Table storage
  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic [CW-1:0]      count, count_next;

  // Captured item
  cmd_e               cur_cmd;
  logic [TAG_LEN-1:0] cur_tag;
  logic [NAME_W-1:0]  cur_name;
  logic [TIME_W-1:0]  cur_now;
  logic [TIME_W-1:0]  add_deadline;
  logic [TIME_W:0]    dl_sum;

  // Scan pipeline
  logic [IW-1:0]      idx;
  logic [IW-1:0]      idx_d;
  logic               vld_d;
  logic               eval_en;
  entry_t             rd_entry;

  // Finders
  logic               match_found;
  logic [IW-1:0]      match_idx;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic               exp_found;
  logic [IW-1:0]      exp_idx;
  entry_t             exp_entry;

  logic               hit_match, hit_free, hit_exp;
  ptt_out_t           rsp_next;

  assign stat.scan_last = (idx == IW'(DEPTH - 1));

  // Saturating deadline for an add
  assign dl_sum = {1'b0, request.now_time} + (TIME_W + 1)'(request.timeout);

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_cmd      <= request.command;
      cur_tag      <= request.corr_tag[TAG_LEN-1:0];
      cur_name     <= request.name_code;
      cur_now      <= request.now_time;
      add_deadline <= dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
    end
  end

  // Scan index and registered entry read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.scan) begin
      idx <= idx + 1'b1;
    end
    if (cmd.scan) begin
      rd_entry <= mem[idx];
      vld_d    <= valid[idx];
      idx_d    <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_en <= 1'b0;
    end else begin
      eval_en <= cmd.scan;
    end
  end

  // Per-entry tests
  assign hit_match = vld_d && (rd_entry.tag == cur_tag) && !match_found;
  assign hit_free  = !vld_d && !free_found;
  assign hit_exp   = vld_d && (rd_entry.deadline < cur_now) &&
                     (!exp_found || (rd_entry.deadline < exp_entry.deadline));

  // Finders: first match, first free slot, earliest expired
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      exp_found   <= 1'b0;
    end else if (eval_en) begin
      if (hit_match) begin
        match_found <= 1'b1;
      end
      if (hit_free) begin
        free_found <= 1'b1;
      end
      if (hit_exp) begin
        exp_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_en) begin
      if (hit_match) begin
        match_idx <= idx_d;
      end
      if (hit_free) begin
        free_idx <= idx_d;
      end
      if (hit_exp) begin
        exp_idx   <= idx_d;
        exp_entry <= rd_entry;
      end
    end
  end

  // Result and count update at commit
  always_comb begin
    rsp_next   = '0;
    count_next = count;
    case (cur_cmd)
      CMD_ADD: begin
        if (free_found) begin
          count_next = count + 1'b1;
        end else begin
          rsp_next.status = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (match_found) begin
          count_next = count - 1'b1;
        end else begin
          rsp_next.status = STAT_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        rsp_next.is_pending = match_found;
      end
      CMD_EXPIRE: begin
        if (exp_found) begin
          rsp_next.expired_found = 1'b1;
          rsp_next.expired_slot  = 3'(exp_idx);
          rsp_next.expired_tag   = TAG_W'(exp_entry.tag);
          rsp_next.expired_name  = exp_entry.name;
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    rsp_next.entry_count = 4'(count_next);
  end

  // Valid bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
      if (cur_cmd == CMD_ADD && free_found) begin
        valid[free_idx] <= 1'b1;
      end else if (cur_cmd == CMD_REMOVE && match_found) begin
        valid[match_idx] <= 1'b0;
      end
    end
  end

  // Entry memory write
  always_ff @(posedge clk) begin
    if (cmd.commit && cur_cmd == CMD_ADD && free_found) begin
      mem[free_idx] <= '{tag: cur_tag, name: cur_name, deadline: add_deadline};
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      response <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
  end

  // Count tracks the valid bits
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid)))
    else $error("entry count differs from valid bits");

  // A result follows each commit and reports the updated count
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done && (response.entry_count == 4'(count)))
    else $error("result missing or count mismatch");

  // A successful add makes its slot valid
  a_add_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cur_cmd == CMD_ADD && free_found) |=> valid[$past(free_idx)])
    else $error("added slot not valid");

endmodule

[src/pending_request_timeout_table.sv]
// Pending request timeout table: one item in, one result out per item.
// Each item passes through the accept cycle, a scan of one table entry per cycle,
// a drain cycle and a commit cycle; no new item is accepted while busy is high.
// The result and done are both registered from the commit.
// done is high for one cycle with each new result; the receiver cannot stall.
// Synchronous reset clears all valid bits and the entry count; no clearing pass.
module pending_request_timeout_table
  import ptt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 8,
  parameter int unsigned TAG_BITS    = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ptt_in_t  request,
  output logic     busy,
  output ptt_out_t response,
  output logic     done
);

  ptt_cmd_t  cmd;
  ptt_stat_t stat;

  // Sequencer
  ptt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table, scan and result
  ptt_datapath #(
    .DEPTH   (TABLE_DEPTH),
    .TAG_LEN (TAG_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .stat     (stat),
    .response (response),
    .done     (done)
  );

endmodule

[test/tb_pending_request_timeout_table.sv]
// Testbench for pending_request_timeout_table: directed and random command items,
// each result checked against a shadow copy of the request table.
// Depends on ptt_pkg and the pending_request_timeout_table RTL.
module tb_pending_request_timeout_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int unsigned       DEPTH        = 8;
  localparam int unsigned       POOL_SIZE    = 12;
  localparam int unsigned       MAX_REPORTS  = 10;
  localparam int unsigned       DRAIN_CYCLES = DEPTH + 8;
  localparam logic [TIME_W-1:0] TIME_MAX     = '1;
  localparam logic [TMO_W-1:0]  TMO_MAX      = '1;
  localparam logic [TAG_W-1:0]  TAG_ONES     = '1;
  localparam logic [TAG_W-1:0]  DUP_TAG      = 64'hA5A5_5A5A_0F0F_F0F0;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  ptt_in_t  request = '0;
  logic     busy;
  ptt_out_t response;
  logic     done;

  pending_request_timeout_table #(
    .TABLE_DEPTH(DEPTH),
    .TAG_BITS   (TAG_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .response(response),
    .done    (done)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the request table
  logic              shadow_valid    [DEPTH];
  logic [TAG_W-1:0]  shadow_tag      [DEPTH];
  logic [NAME_W-1:0] shadow_name     [DEPTH];
  logic [TIME_W-1:0] shadow_deadline [DEPTH];
  int unsigned       shadow_count;

  ptt_out_t          awaited_responses [$];
  ptt_out_t          oldest_response;
  int unsigned       errors = 0;
  logic [TIME_W-1:0] clock_ms;
  logic [TAG_W-1:0]  tag_pool [POOL_SIZE];

  // Lowest valid slot holding the tag, or -1
  function automatic int find_pending(logic [TAG_W-1:0] tag);
    for (int i = 0; i < DEPTH; i++) begin
      if (shadow_valid[i] && shadow_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the response it earns
  function automatic ptt_out_t apply_to_shadow(ptt_in_t rq);
    ptt_out_t        rsp;
    int              hit;
    logic [TIME_W:0] sum;
    rsp = '0;
    hit = -1;
    case (rq.command)
      CMD_ADD: begin
        if (shadow_count < DEPTH) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!shadow_valid[i] && hit < 0) hit = i;
          end
        end
        if (hit < 0) begin
          rsp.status = STAT_FULL;
        end else begin
          // deadline saturates at the top of the time range
          sum = {1'b0, rq.now_time} + (TIME_W + 1)'(rq.timeout);
          shadow_valid[hit]    = 1'b1;
          shadow_tag[hit]      = rq.corr_tag;
          shadow_name[hit]     = rq.name_code;
          shadow_deadline[hit] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        hit = find_pending(rq.corr_tag);
        if (hit < 0) begin
          rsp.status = STAT_NOT_FOUND;
        end else begin
          shadow_valid[hit] = 1'b0;
          shadow_tag[hit]   = '0;
          shadow_count--;
        end
      end
      CMD_LOOKUP: begin
        rsp.is_pending = (find_pending(rq.corr_tag) >= 0);
      end
      default: begin
        // earliest strictly expired entry, lowest index on a tie
        for (int i = 0; i < DEPTH; i++) begin
          if (shadow_valid[i] && shadow_deadline[i] < rq.now_time &&
              (hit < 0 || shadow_deadline[i] < shadow_deadline[hit])) hit = i;
        end
        if (hit >= 0) begin
          rsp.expired_found = 1'b1;
          rsp.expired_slot  = 3'(hit);
          rsp.expired_tag   = shadow_tag[hit];
          rsp.expired_name  = shadow_name[hit];
        end
      end
    endcase
    rsp.entry_count = 4'(shadow_count);
    return rsp;
  endfunction

  function automatic ptt_in_t make_item(cmd_e cmd, logic [TAG_W-1:0] tag,
                                        logic [NAME_W-1:0] name_code,
                                        logic [TMO_W-1:0] tmo, logic [TIME_W-1:0] now);
    ptt_in_t rq;
    rq.command   = cmd;
    rq.corr_tag  = tag;
    rq.name_code = name_code;
    rq.timeout   = tmo;
    rq.now_time  = now;
    return rq;
  endfunction

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // Present one item after an idle gap; start stays high on return
  task automatic issue_request(ptt_in_t rq, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_responses.push_back(apply_to_shadow(rq));
  endtask

  // Stop sending until every awaited result has come back
  task automatic settle_table();
    start <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // empty table: cleared entries with tag 0 must not match
    issue_request(make_item(CMD_LOOKUP, '0, '0, '0, '0), draw_gap(0));
    issue_request(make_item(CMD_REMOVE, '0, '0, '0, '0), draw_gap(0));
    issue_request(make_item(CMD_EXPIRE, '0, '0, '0, TIME_MAX), draw_gap(0));
    // fill with field extremes, a saturating deadline and a duplicate tag on a tie
    issue_request(make_item(CMD_ADD, '0, '0, '0, '0), draw_gap(0));
    issue_request(make_item(CMD_ADD, TAG_ONES, 16'hFFFF, TMO_MAX, TIME_MAX), draw_gap(0));
    issue_request(make_item(CMD_ADD, DUP_TAG, 16'h1234, 31'd100, 40'd1000), draw_gap(0));
    issue_request(make_item(CMD_ADD, DUP_TAG, 16'h5678, 31'd50, 40'd1050), draw_gap(0));
    for (int i = 1; i <= 4; i++) begin
      issue_request(make_item(CMD_ADD, 64'(i), 16'(i), 31'd10, 40'h80_0000_0000),
                    draw_gap(0));
    end
    // table full
    issue_request(make_item(CMD_ADD, 64'h77, 16'h77, 31'd5, 40'd5), draw_gap(0));
    // expiry is strict: deadline 0 is not expired at time 0
    issue_request(make_item(CMD_EXPIRE, '0, '0, '0, 40'd0), draw_gap(0));
    issue_request(make_item(CMD_EXPIRE, '0, '0, '0, 40'd1), draw_gap(0));
    issue_request(make_item(CMD_REMOVE, '0, '0, '0, '0), draw_gap(0));
    // tie on deadline goes to the lower slot; remove takes the lowest duplicate
    issue_request(make_item(CMD_EXPIRE, '0, '0, '0, 40'd1101), draw_gap(0));
    issue_request(make_item(CMD_LOOKUP, DUP_TAG, '0, '0, '0), draw_gap(0));
    issue_request(make_item(CMD_REMOVE, DUP_TAG, '0, '0, '0), draw_gap(0));
    issue_request(make_item(CMD_EXPIRE, '0, '0, '0, 40'd1101), draw_gap(0));
    issue_request(make_item(CMD_REMOVE, DUP_TAG, '0, '0, '0), draw_gap(0));
    issue_request(make_item(CMD_LOOKUP, DUP_TAG, '0, '0, '0), draw_gap(0));
    // reuse of the first free slot
    issue_request(make_item(CMD_ADD, 64'h5555_AAAA_5555_AAAA, 16'hAAAA, TMO_MAX, TIME_MAX),
                  draw_gap(0));
    issue_request(make_item(CMD_EXPIRE, '0, '0, '0, TIME_MAX), draw_gap(0));
    issue_request(make_item(CMD_REMOVE, TAG_ONES, '0, '0, '0), draw_gap(0));
  endtask

  // Mixed commands on a small tag pool, occasional full-range fields
  task automatic test_random_mix(int unsigned count);
    int unsigned       roll;
    cmd_e              cmd;
    logic [TAG_W-1:0]  tag;
    logic [TMO_W-1:0]  tmo;
    logic [TIME_W-1:0] now;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      clock_ms += TIME_W'($urandom_range(0, 40));
      now = clock_ms;
      tmo = TMO_W'($urandom_range(0, 300));
      if ($urandom_range(0, 15) == 0) now = {8'($urandom()), $urandom()};
      if ($urandom_range(0, 15) == 0) tmo = 31'($urandom());
      tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 19) == 0) tag = {$urandom(), $urandom()};
      cmd = roll < 35 ? CMD_ADD : roll < 65 ? CMD_REMOVE : roll < 80 ? CMD_LOOKUP : CMD_EXPIRE;
      issue_request(make_item(cmd, tag, 16'($urandom()), tmo, now), draw_gap((k % 100) >= 70));
    end
  endtask

  // Alternating fill and drain phases; removes mostly hit live entries
  task automatic test_fill_drain(int unsigned count);
    int unsigned       roll;
    int unsigned       pick;
    bit                filling;
    cmd_e              cmd;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] now;
    for (int k = 0; k < count; k++) begin
      filling = ((k / 40) % 2) == 0;
      roll = $urandom_range(0, 99);
      clock_ms += TIME_W'($urandom_range(0, 30));
      now = clock_ms;
      pick = $urandom_range(0, DEPTH - 1);
      tag = $urandom_range(0, 1) ? tag_pool[$urandom_range(0, POOL_SIZE - 1)]
                                 : {$urandom(), $urandom()};
      if (filling) begin
        cmd = roll < 70 ? CMD_ADD : roll < 85 ? CMD_LOOKUP : CMD_EXPIRE;
      end else begin
        cmd = roll < 65 ? CMD_REMOVE : roll < 80 ? CMD_LOOKUP : CMD_EXPIRE;
        if (shadow_valid[pick] && roll < 90) tag = shadow_tag[pick];
      end
      if (cmd == CMD_EXPIRE) now = clock_ms + TIME_W'($urandom_range(0, 600));
      issue_request(make_item(cmd, tag, 16'($urandom()), 31'($urandom_range(0, 500)), now),
                    draw_gap((k % 90) >= 65));
    end
  endtask

  task automatic check_field(string field, logic [TAG_W-1:0] got, logic [TAG_W-1:0] want);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %s: expected %0h, got %0h at %0t", field, want, got, $time);
    end
  endtask

  // Compare every result with the oldest awaited one
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (awaited_responses.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result %h with none awaited at %0t", response, $time);
      end else begin
        oldest_response = awaited_responses.pop_front();
        check_field("status", TAG_W'(response.status), TAG_W'(oldest_response.status));
        check_field("is_pending", TAG_W'(response.is_pending),
                    TAG_W'(oldest_response.is_pending));
        check_field("expired_found", TAG_W'(response.expired_found),
                    TAG_W'(oldest_response.expired_found));
        check_field("expired_slot", TAG_W'(response.expired_slot),
                    TAG_W'(oldest_response.expired_slot));
        check_field("expired_tag", response.expired_tag, oldest_response.expired_tag);
        check_field("expired_name", TAG_W'(response.expired_name),
                    TAG_W'(oldest_response.expired_name));
        check_field("entry_count", TAG_W'(response.entry_count),
                    TAG_W'(oldest_response.entry_count));
      end
    end
  end

  // Test sequence
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_valid[i]    = 1'b0;
      shadow_tag[i]      = '0;
      shadow_name[i]     = '0;
      shadow_deadline[i] = '0;
    end
    shadow_count = 0;
    clock_ms     = '0;
    tag_pool[0]  = '0;
    tag_pool[1]  = TAG_ONES;
    for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = {$urandom(), $urandom()};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    settle_table();
    test_random_mix(900);
    settle_table();
    test_fill_drain(700);
    settle_table();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && awaited_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
